// ===== sv/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg - shared types and constants for the date-plus-days unit
// Word layouts, controller/datapath command and status groups, calendar
// constants and the month length lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package gdad_pkg;

  localparam int DAY_BITS    = 5;
  localparam int MONTH_BITS  = 4;
  localparam int YEAR_BITS   = 14;
  localparam int OFFSET_PORT = 16;

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

  localparam logic [YEAR_BITS-1:0] YEAR_MAX    = 14'h3FFF;
  localparam logic [YEAR_BITS-1:0] CENTURY     = 14'd100;
  localparam logic [YEAR_BITS-1:0] CENTURY_END = 14'd99;

  // Year / 100 by reciprocal: (year * 5243) >> 19 is exact for any 14-bit
  // year. The first step forms the quotient, the second the remainder.
  localparam int DIV_STEPS   = 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int QUO_BITS    = 8;
  localparam int RECIP_BITS  = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_BITS-1:0] RECIP_100 = 13'd5243;

  localparam logic [DAY_BITS-1:0] LEN_31   = 5'd31;
  localparam logic [DAY_BITS-1:0] LEN_30   = 5'd30;
  localparam logic [DAY_BITS-1:0] LEN_29   = 5'd29;
  localparam logic [DAY_BITS-1:0] LEN_28   = 5'd28;

  typedef struct packed {
    logic [DAY_BITS-1:0]    start_day;
    logic [MONTH_BITS-1:0]  start_month;
    logic [YEAR_BITS-1:0]   start_year;
    logic [OFFSET_PORT-1:0] day_offset;
  } in_word_t;

  typedef struct packed {
    logic [DAY_BITS-1:0]   result_day;
    logic [MONTH_BITS-1:0] result_month;
    logic [YEAR_BITS-1:0]  result_year;
  } out_word_t;

  typedef struct packed {
    logic load;        // capture a new input word
    logic div_step;    // one step of the year / 100 split
    logic month_step;  // take one month off the day count
    logic out_load;    // move the finished date into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;    // current division step is the final one
    logic fits;        // day count fits in the current month
  } dp_status_t;

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] month,
                                                     input logic leap);
    logic [DAY_BITS-1:0] len;
    case (month)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
      MONTH_FEB: len = leap ? LEN_29 : LEN_28;
      default:   len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gdad_if.sv =====
// ----------------------------------------------------------------------------
// gdad_if - valid/ready channels of the date-plus-days unit
// One interface for the request word, one for the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdad_in_if;
  logic               valid;
  logic               ready;
  gdad_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gdad_out_if;
  logic                valid;
  logic                ready;
  gdad_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/gregorian_date_add_days_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit - Gregorian date plus a day offset
// Adds a non-negative day count to a date and walks the result forward one
// month per cycle with the full leap-year rule.
// ----------------------------------------------------------------------------
// Usage:
//   request carries start_day, start_month, start_year and day_offset as one
//   word; a word is taken when request.valid and request.ready are both high.
//   result carries result_day, result_month and result_year, one word for
//   each request word, handed over on result.valid and result.ready.
//   Only the low OFFSET_BITS bits of day_offset (at most 16) are used.
// Sequence:
//   load, split the year into century and year within century (reciprocal
//   multiply, then remainder), then one month step per month crossed and a
//   final step that hands the date to the output register; a full 16-bit
//   offset crosses up to roughly 2160 months. One word is in work at a time.
//   The month step loop sets the rate.
// Reset:
//   rst is synchronous; it drops any word in work and clears result.valid.
// Stall:
//   the finished date waits in the output register; the next request word is
//   taken meanwhile, and its stepping holds at the last month until the
//   output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_add_days_unit #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  gdad_in_if.sink    request,
  gdad_out_if.source result
);

  gdad_pkg::ctrl_cmd_t  cmd;
  gdad_pkg::dp_status_t status;

  // Sequencer: accept, divide, step months, hand over.
  gdad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: working date, century split and the output date register.
  gdad_dpath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dpath (
    .clk      (clk),
    .in_word  (request.data),
    .cmd      (cmd),
    .status   (status),
    .out_word (result.data)
  );

endmodule

`default_nettype wire

// ===== sv/gdad_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdad_ctrl - sequencer of the date-plus-days unit
// Steps through load, year/100 division and month stepping, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gdad_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire gdad_pkg::dp_status_t status,
  output      gdad_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_STEP = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!status.fits) begin
          cmd.month_step = 1'b1;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gdad_dpath.sv =====
// ----------------------------------------------------------------------------
// gdad_dpath - datapath of the date-plus-days unit
// Day/month/year registers, a reciprocal year / 100 split, and the
// month length subtractor; holds the output date register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdad_dpath #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic                 clk,
  input  wire gdad_pkg::in_word_t   in_word,
  input  wire gdad_pkg::ctrl_cmd_t  cmd,
  output      gdad_pkg::dp_status_t status,
  output      gdad_pkg::out_word_t  out_word
);

  localparam int USED_BITS = (OFFSET_BITS < gdad_pkg::OFFSET_PORT) ? OFFSET_BITS
                                                                   : gdad_pkg::OFFSET_PORT;
  localparam int DAY_W     = USED_BITS + 1;
  localparam int PROD_W    = gdad_pkg::YEAR_BITS + gdad_pkg::RECIP_BITS;

  logic [DAY_W-1:0]                  day;
  logic [gdad_pkg::MONTH_BITS-1:0]   month;
  logic [gdad_pkg::YEAR_BITS-1:0]    year;
  // Division remainder; after the division it is year mod 100.
  logic [gdad_pkg::YEAR_BITS-1:0]    rem;
  logic [1:0]                        cent_mod4;
  logic [gdad_pkg::DIV_CNT_W-1:0]    cnt;
  logic [gdad_pkg::QUO_BITS-1:0]     quo;

  logic [PROD_W-1:0]                 prod;
  logic [gdad_pkg::YEAR_BITS-1:0]    cent_base;
  logic                              leap;
  logic [gdad_pkg::DAY_BITS-1:0]     len;
  logic [gdad_pkg::MONTH_BITS-1:0]   load_month;

  assign prod      = PROD_W'(year) * PROD_W'(gdad_pkg::RECIP_100);
  assign cent_base = gdad_pkg::YEAR_BITS'(quo) * gdad_pkg::CENTURY;

  // Leap: year mod 4 equals rem mod 4; century years need century mod 4 zero.
  assign leap = (rem[1:0] == 2'b00) && ((rem != '0) || (cent_mod4 == 2'b00));
  assign len  = gdad_pkg::month_len(month, leap);

  assign status.div_last = (cnt == '0);
  assign status.fits     = (day <= DAY_W'(len));

  always_comb begin
    if ((in_word.start_month < gdad_pkg::MONTH_JAN) ||
        (in_word.start_month > gdad_pkg::MONTH_DEC)) begin
      load_month = gdad_pkg::MONTH_JAN;
    end else begin
      load_month = in_word.start_month;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day       <= DAY_W'(in_word.start_day) + DAY_W'(in_word.day_offset[USED_BITS-1:0]);
      month     <= load_month;
      year      <= in_word.start_year;
      rem       <= in_word.start_year;
      cnt       <= gdad_pkg::DIV_CNT_W'(gdad_pkg::DIV_STEPS - 1);
      cent_mod4 <= 2'b00;
    end else if (cmd.div_step) begin
      if (cnt != '0) begin
        // first step: quotient by reciprocal multiply
        quo       <= prod[gdad_pkg::RECIP_SHIFT +: gdad_pkg::QUO_BITS];
        cent_mod4 <= prod[gdad_pkg::RECIP_SHIFT +: 2];
      end else begin
        // second step: year within century
        rem <= year - cent_base;
      end
      cnt <= cnt - 1'b1;
    end else if (cmd.month_step) begin
      day <= day - DAY_W'(len);
      if (month == gdad_pkg::MONTH_DEC) begin
        month <= gdad_pkg::MONTH_JAN;
        if (year == gdad_pkg::YEAR_MAX) begin
          // wrap to year zero, which starts a fresh century
          year      <= '0;
          rem       <= '0;
          cent_mod4 <= 2'b00;
        end else begin
          year <= year + 1'b1;
          if (rem == gdad_pkg::CENTURY_END) begin
            rem       <= '0;
            cent_mod4 <= cent_mod4 + 1'b1;
          end else begin
            rem <= rem + 1'b1;
          end
        end
      end else begin
        month <= month + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.result_day   <= day[gdad_pkg::DAY_BITS-1:0];
      out_word.result_month <= month;
      out_word.result_year  <= year;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/gregorian_date_add_days_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit_test - self-checking bench for date plus days
// Sends dated request words with day offsets through the valid/ready request
// channel. Each result word is checked field by field against a calendar walk
// that is computed inside the bench. The run covers directed corner dates and
// then random dates, with random idle bursts on both channels and one long
// hold-off on the result side.
// ----------------------------------------------------------------------------

module gregorian_date_add_days_unit_test;

  // Offset bits the block is built to use, and bench pacing.
  localparam int OFFSET_USED  = 16;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_WORDS = 250;
  localparam int QUIET_TAIL   = 40;     // last words go through with no idling
  localparam int HOLD_AFTER   = 60;     // result count that starts the long hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  // A full 16-bit offset walks about 2160 months at one month per cycle;
  // allow several times that plus the long hold.
  localparam int STALL_LIMIT  = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gdad_in_if  request_ch ();
  gdad_out_if result_ch ();

  gregorian_date_add_days_unit #(
    .OFFSET_BITS(OFFSET_USED)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .request(request_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar walk: add the offset to the day, then take whole months off
  // while the day count is larger than the current month.
  // --------------------------------------------------------------------------
  function automatic bit is_leap(input int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned month,
                                                input int unsigned year);
    case (month)
      gdad_pkg::MONTH_APR, gdad_pkg::MONTH_JUN,
      gdad_pkg::MONTH_SEP, gdad_pkg::MONTH_NOV: return 30;
      gdad_pkg::MONTH_FEB: return is_leap(year) ? 29 : 28;
      default:             return 31;
    endcase
  endfunction

  function automatic gdad_pkg::out_word_t date_after_offset(input gdad_pkg::in_word_t w,
                                                            output int unsigned months_crossed);
    int unsigned         day;
    int unsigned         month;
    int unsigned         year;
    int unsigned         len;
    gdad_pkg::out_word_t r;
    day            = w.start_day;
    month          = w.start_month;
    year           = w.start_year;
    months_crossed = 0;
    // Month codes outside 1..12 count as January of the same year.
    if (month < gdad_pkg::MONTH_JAN || month > gdad_pkg::MONTH_DEC) month = gdad_pkg::MONTH_JAN;
    day += w.day_offset & ((1 << OFFSET_USED) - 1);
    len = days_in_month(month, year);
    while (day > len) begin
      day -= len;
      month++;
      months_crossed++;
      if (month > gdad_pkg::MONTH_DEC) begin
        month = gdad_pkg::MONTH_JAN;
        // The year lives in 14 bits: past the top it wraps to year 0.
        year  = (year + 1) & gdad_pkg::YEAR_MAX;
      end
      len = days_in_month(month, year);
    end
    r.result_day   = gdad_pkg::DAY_BITS'(day);
    r.result_month = gdad_pkg::MONTH_BITS'(month);
    r.result_year  = gdad_pkg::YEAR_BITS'(year);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  gdad_pkg::in_word_t  request_words[$];   // words still to be offered
  gdad_pkg::out_word_t due_dates[$];       // predicted dates, oldest first
  int unsigned words_total    = 0;
  int unsigned words_directed = 0;
  int unsigned words_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned failures       = 0;
  int unsigned months_walked  = 0;
  int unsigned longest_walk   = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  int unsigned hold_left      = 0;
  int unsigned idle_cycles    = 0;
  bit          hold_done      = 1'b0;
  bit          tail_phase     = 1'b0;

  task automatic queue_date(input int unsigned day, input int unsigned month,
                            input int unsigned year, input int unsigned offset);
    gdad_pkg::in_word_t w;
    w.start_day   = gdad_pkg::DAY_BITS'(day);
    w.start_month = gdad_pkg::MONTH_BITS'(month);
    w.start_year  = gdad_pkg::YEAR_BITS'(year);
    w.day_offset  = gdad_pkg::OFFSET_PORT'(offset);
    request_words.push_back(w);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: predict each accepted word, then offer the next one or
  // idle for a random burst. Hold the word steady while ready is low.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int unsigned crossed;
    if (rst) begin
      request_ch.valid <= 1'b0;
    end else begin
      if (request_ch.valid && request_ch.ready) begin
        due_dates.push_back(date_after_offset(request_ch.data, crossed));
        months_walked += crossed;
        if (crossed > longest_walk) longest_walk = crossed;
        words_taken++;
      end
      tail_phase = (words_taken + QUIET_TAIL >= words_total);
      if (!request_ch.valid || request_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          request_ch.valid <= 1'b0;
        end else if (request_words.size() == 0) begin
          request_ch.valid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
          // Start a random idle burst.
          send_gap = $urandom_range(0, 9);
          request_ch.valid <= 1'b0;
        end else begin
          request_ch.valid <= 1'b1;
          request_ch.data  <= request_words.pop_front();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted word against the oldest prediction
  // and drive ready with random stall bursts and one long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    gdad_pkg::out_word_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (due_dates.size() == 0) begin
          $error("result word with no prediction pending: %0d-%0d-%0d",
                 result_ch.data.result_year, result_ch.data.result_month,
                 result_ch.data.result_day);
          failures++;
        end else begin
          want = due_dates.pop_front();
          if (result_ch.data.result_day !== want.result_day) begin
            $error("result_day: expected %0d, got %0d",
                   want.result_day, result_ch.data.result_day);
            failures++;
          end
          if (result_ch.data.result_month !== want.result_month) begin
            $error("result_month: expected %0d, got %0d",
                   want.result_month, result_ch.data.result_month);
            failures++;
          end
          if (result_ch.data.result_year !== want.result_year) begin
            $error("result_year: expected %0d, got %0d",
                   want.result_year, result_ch.data.result_year);
            failures++;
          end
        end
        // Hold off long enough for the block to fill and stall its input
        // while the driver keeps offering.
        if (!hold_done && results_seen == HOLD_AFTER) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 9);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no word moves on either channel for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    gdad_pkg::in_word_t w;
    int unsigned        pick;
    int unsigned        span;
    request_ch.valid = 1'b0;
    request_ch.data  = '0;
    result_ch.ready  = 1'b0;

    // Plain date, nothing to add.
    queue_date(15, 6, 2024, 0);
    // Day zero: stays zero with no offset, steps normally with one.
    queue_date(0, 3, 2023, 0);
    queue_date(0, 3, 2023, 1);
    // Month codes outside the calendar fold to January.
    queue_date(20, 0, 2023, 15);
    queue_date(31, 13, 2023, 1);
    queue_date(10, 15, 2023, 30);
    // Day past the end of its month rolls forward even with no offset.
    queue_date(31, 4, 2023, 0);
    queue_date(31, 2, 2021, 0);
    // End of February across the leap rule: plain leap, common year,
    // century that is not a leap year, 400-year leap, and year zero.
    queue_date(28, 2, 2024, 1);
    queue_date(28, 2, 2023, 1);
    queue_date(28, 2, 1900, 1);
    queue_date(28, 2, 2000, 1);
    queue_date(28, 2, 2100, 1);
    queue_date(28, 2, 0, 1);
    // December into January of the next year.
    queue_date(31, 12, 1999, 1);
    // Top of the 14-bit year wraps to year zero.
    queue_date(31, 12, 16383, 1);
    queue_date(1, 12, 16383, 400);
    // Largest offsets, including one that walks across the year wrap.
    queue_date(1, 1, 1, 65535);
    queue_date(31, 12, 9999, 65535);
    queue_date(1, 1, 16300, 65535);
    // All-zero and all-ones words.
    queue_date(0, 0, 0, 0);
    queue_date(31, 15, 16383, 65535);
    words_directed = request_words.size();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Any bit pattern in the day, month and year fields.
        w.start_day   = gdad_pkg::DAY_BITS'($urandom_range(0, 31));
        w.start_month = gdad_pkg::MONTH_BITS'($urandom_range(0, 15));
        w.start_year  = gdad_pkg::YEAR_BITS'($urandom_range(0, 16383));
      end else if (pick == 1) begin
        // End of February in a century year or year near the top.
        w.start_month = gdad_pkg::MONTH_FEB;
        w.start_year  = ($urandom_range(0, 1) == 0)
                        ? gdad_pkg::YEAR_BITS'($urandom_range(0, 163) * 100)
                        : gdad_pkg::YEAR_BITS'($urandom_range(16300, 16383));
        w.start_day   = gdad_pkg::DAY_BITS'($urandom_range(27, 29));
      end else begin
        w.start_month = gdad_pkg::MONTH_BITS'($urandom_range(1, 12));
        w.start_year  = gdad_pkg::YEAR_BITS'($urandom_range(1, 9999));
        w.start_day   = gdad_pkg::DAY_BITS'($urandom_range(1, days_in_month(w.start_month,
                                                                            w.start_year)));
      end
      // Keep most walks short; a few go the whole offset range.
      span = $urandom_range(0, 19);
      if (span < 14)       w.day_offset = gdad_pkg::OFFSET_PORT'($urandom_range(0, 400));
      else if (span < 18)  w.day_offset = gdad_pkg::OFFSET_PORT'($urandom_range(401, 4000));
      else if (span == 18) w.day_offset = gdad_pkg::OFFSET_PORT'($urandom_range(4001, 65535));
      else                 w.day_offset = gdad_pkg::OFFSET_PORT'($urandom);
      request_words.push_back(w);
    end
    words_total = request_words.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    wait (words_taken == words_total);
    wait (due_dates.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d request words (%0d directed), %0d result words checked",
             words_total, words_directed, results_seen);
    $display("summary: %0d months stepped in all, longest walk %0d months",
             months_walked, longest_walk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gdad_pkg.sv
sv/gdad_if.sv
sv/gdad_ctrl.sv
sv/gdad_dpath.sv
sv/gregorian_date_add_days_unit.sv
tb/sv/gregorian_date_add_days_unit_test.sv
